[hw/rtl/tfn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

  // Coordinate and normal formats.
  localparam int CoordBits = 24;
  localparam int FracBits  = 14;
  localparam int OutBits   = 16;

  // Derived datapath widths.
  localparam int EdgeBits   = CoordBits + 1;
  localparam int ProdBits   = 2 * EdgeBits;
  localparam int CrossBits  = ProdBits + 1;
  localparam int LenBits    = $clog2(CrossBits + 1);
  localparam int MagBits    = 30;
  localparam int SumBits    = 2 * MagBits + 2;
  localparam int RootBits   = MagBits + 1;
  localparam int RemSqBits  = RootBits + 3;
  localparam int NumBits    = MagBits + FracBits + 1;
  localparam int QuoBits    = FracBits + 2;
  localparam int DivRemBits = RootBits + 1;
  localparam int InBits     = 9 * CoordBits;
  localparam int InBytes    = (InBits + 7) / 8;
  localparam int OutDBits   = 3 * OutBits;
  localparam int OutBytes   = (OutDBits + 7) / 8;

  // Word moving through the square root chain.
  typedef struct packed {
    logic                          valid;
    logic                          degen;
    logic [2:0]                    neg;
    logic [2:0][MagBits-1:0]       mag;
    logic [SumBits-1:0]            rad;
    logic [RemSqBits-1:0]          rem;
    logic [RootBits-1:0]           root;
  } sqrt_t;

  // Word moving through the divider chain, three lanes share one divisor.
  typedef struct packed {
    logic                          valid;
    logic                          degen;
    logic [2:0]                    neg;
    logic [RootBits-1:0]           dvsr;
    logic [2:0][DivRemBits-1:0]    rem;
    logic [2:0][QuoBits-1:0]       num;
    logic [2:0][QuoBits-1:0]       quo;
  } div_t;

endpackage

`default_nettype wire

[hw/rtl/tfn_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfn_sqrt_cell import tfn_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   en_i,
  input  sqrt_t cell_i,
  output sqrt_t cell_o
);

  logic [RemSqBits-1:0] part;
  logic [RemSqBits-1:0] trial;
  logic                 fit;
  sqrt_t                cell_d;
  sqrt_t                cell_q;

  // One root bit per cell: bring down two radicand bits and try 4r+1.
  always_comb begin
    part        = {cell_i.rem[RemSqBits-3:0], cell_i.rad[SumBits-1 -: 2]};
    trial       = {1'b0, cell_i.root, 2'b01};
    fit         = (part >= trial);
    cell_d      = cell_i;
    cell_d.rad  = cell_i.rad << 2;
    cell_d.rem  = fit ? (part - trial) : part;
    cell_d.root = {cell_i.root[RootBits-2:0], fit};
  end

  // Only the valid flag is reset; the data fields simply hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

[hw/rtl/tfn_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfn_div_cell import tfn_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  en_i,
  input  div_t cell_i,
  output div_t cell_o
);

  logic [2:0][DivRemBits-1:0] part;
  logic [2:0]                 fit;
  div_t                       cell_d;
  div_t                       cell_q;

  // One quotient bit per lane per cell, restoring division.
  always_comb begin
    cell_d = cell_i;
    for (int k = 0; k < 3; k++) begin
      part[k] = {cell_i.rem[k][DivRemBits-2:0], cell_i.num[k][QuoBits-1]};
      fit[k]  = (part[k] >= {1'b0, cell_i.dvsr});
      cell_d.rem[k] = fit[k] ? (part[k] - {1'b0, cell_i.dvsr}) : part[k];
      cell_d.num[k] = cell_i.num[k] << 1;
      cell_d.quo[k] = {cell_i.quo[k][QuoBits-2:0], fit[k]};
    end
  end

  // Only the valid flag is reset; the data fields simply hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.valid <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

[hw/rtl/triangle_face_normal_unit.sv]
// Throughput: one triangle per cycle; every stage and every square root and divider cell
// advances together whenever the output register is empty or being taken.
// Reset: rst_ni is asynchronous and active low; it clears all valid flags, datapath
// registers keep whatever they hold. The unit carries no state between triangles.
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal_unit import tfn_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, from bit 0 up.
  input  wire  [InBytes*8-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // normal_x, normal_y, normal_z, from bit 0 up.
  output logic [OutBytes*8-1:0]  m_axis_tdata,
  // degenerate.
  output logic                   m_axis_tuser
);

  // The whole pipeline moves as one: it stalls only when a finished word
  // sits in the output register and the sink does not take it.
  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: edge vectors e1 = v1 - v0 and e2 = v2 - v0.
  logic signed [CoordBits-1:0] vin [9];
  logic signed [EdgeBits-1:0]  e1_d [3];
  logic signed [EdgeBits-1:0]  e2_d [3];
  logic signed [EdgeBits-1:0]  e1_q [3];
  logic signed [EdgeBits-1:0]  e2_q [3];
  logic                        v1_q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vin[i] = s_axis_tdata[i*CoordBits +: CoordBits];
    end
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = EdgeBits'(vin[3+k]) - EdgeBits'(vin[k]);
      e2_d[k] = EdgeBits'(vin[6+k]) - EdgeBits'(vin[k]);
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic signed [ProdBits-1:0] pa_q [3];
  logic signed [ProdBits-1:0] pb_q [3];
  logic                       v2_q;

  // Stage 3: exact cross product split into sign and magnitude.
  logic signed [CrossBits-1:0] cr [3];
  logic [CrossBits-1:0]        cmag_q [3];
  logic [2:0]                  cneg_q;
  logic                        v3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr[k] = CrossBits'(pa_q[k]) - CrossBits'(pb_q[k]);
    end
  end

  // Stage 4: bit length of the largest magnitude.
  logic [CrossBits-1:0] cor;
  logic [LenBits-1:0]   len_d;
  logic [LenBits-1:0]   len_q;
  logic [CrossBits-1:0] lmag_q [3];
  logic [2:0]           lneg_q;
  logic                 v4_q;

  always_comb begin
    cor   = cmag_q[0] | cmag_q[1] | cmag_q[2];
    len_d = '0;
    for (int b = 0; b < CrossBits; b++) begin
      if (cor[b]) begin
        len_d = LenBits'(b + 1);
      end
    end
  end

  // Stage 5: scale so that the largest magnitude lands in [2^29, 2^30).
  logic [CrossBits+MagBits-1:0] shf [3];
  logic [MagBits-1:0]           smag_q [3];
  logic [2:0]                   sneg_q;
  logic                         sdeg_q;
  logic                         v5_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shf[k] = {lmag_q[k], {MagBits{1'b0}}} >> len_q;
    end
  end

  // Stage 6: squares. Stage 7: their sum feeds the square root chain.
  logic [2*MagBits-1:0] sq_q [3];
  logic [MagBits-1:0]   qmag_q [3];
  logic [2:0]           qneg_q;
  logic                 qdeg_q;
  logic                 v6_q;
  sqrt_t                sroot [RootBits+1];
  sqrt_t                sum_q;

  // Only the valid flags are reset; the datapath registers simply hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      sum_q.valid <= 1'b0;
    end else if (en) begin
      v1_q        <= s_axis_tvalid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      sum_q.valid <= v6_q;
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= e1_d[k];
        e2_q[k] <= e2_d[k];
      end
      pa_q[0] <= e1_q[1] * e2_q[2];
      pb_q[0] <= e1_q[2] * e2_q[1];
      pa_q[1] <= e1_q[2] * e2_q[0];
      pb_q[1] <= e1_q[0] * e2_q[2];
      pa_q[2] <= e1_q[0] * e2_q[1];
      pb_q[2] <= e1_q[1] * e2_q[0];
      for (int k = 0; k < 3; k++) begin
        cneg_q[k] <= cr[k][CrossBits-1];
        cmag_q[k] <= cr[k][CrossBits-1] ? (CrossBits'(0) - cr[k]) : cr[k];
        lmag_q[k] <= cmag_q[k];
        smag_q[k] <= shf[k][MagBits-1:0];
        qmag_q[k] <= smag_q[k];
        sq_q[k]   <= smag_q[k] * smag_q[k];
      end
      lneg_q       <= cneg_q;
      len_q        <= len_d;
      sneg_q       <= lneg_q;
      sdeg_q       <= (len_q == '0);
      qneg_q       <= sneg_q;
      qdeg_q       <= sdeg_q;
      sum_q.degen  <= qdeg_q;
      sum_q.neg    <= qneg_q;
      sum_q.mag[0] <= qmag_q[0];
      sum_q.mag[1] <= qmag_q[1];
      sum_q.mag[2] <= qmag_q[2];
      sum_q.rad    <= SumBits'(sq_q[0]) + SumBits'(sq_q[1]) + SumBits'(sq_q[2]);
      sum_q.rem    <= '0;
      sum_q.root   <= '0;
    end
  end

  // Square root chain, one root bit per cell.
  assign sroot[0] = sum_q;

  for (genvar g = 0; g < RootBits; g++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (sroot[g]),
      .cell_o (sroot[g+1])
    );
  end

  // Numerator stage: m * 2^frac + n/2, split into the part that starts the
  // remainder and the low bits that the divider cells bring down one by one.
  sqrt_t                root_w;
  logic [RootBits-1:0]  nfix;
  logic [NumBits-1:0]   numer [3];
  div_t                 num_q;
  div_t                 dchain [QuoBits+1];

  always_comb begin
    root_w = sroot[RootBits];
    nfix   = (root_w.root == '0) ? RootBits'(1) : root_w.root;
    for (int k = 0; k < 3; k++) begin
      numer[k] = {1'b0, root_w.mag[k], {FracBits{1'b0}}} + NumBits'(nfix >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q.valid <= 1'b0;
    end else if (en) begin
      num_q.valid <= root_w.valid;
      num_q.degen <= root_w.degen;
      num_q.neg   <= root_w.neg;
      num_q.dvsr  <= nfix;
      for (int k = 0; k < 3; k++) begin
        num_q.rem[k] <= DivRemBits'(numer[k][NumBits-1:QuoBits]);
        num_q.num[k] <= numer[k][QuoBits-1:0];
        num_q.quo[k] <= '0;
      end
    end
  end

  assign dchain[0] = num_q;

  for (genvar g = 0; g < QuoBits; g++) begin : g_div
    tfn_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (dchain[g]),
      .cell_o (dchain[g+1])
    );
  end

  // Output stage: saturate, apply the sign, zero everything for a
  // degenerate triangle.
  div_t                         fin;
  logic [32:0]                  qx [3];
  logic [OutBits-1:0]           qs [3];
  logic [2:0][OutBits-1:0]      norm_d;
  logic [OutBytes*8-1:0]        data_q;
  logic                         user_q;

  always_comb begin
    fin = dchain[QuoBits];
    for (int k = 0; k < 3; k++) begin
      qx[k] = {{(33-QuoBits){1'b0}}, fin.quo[k]};
      if (fin.neg[k]) begin
        qs[k]     = (qx[k] > 33'd32768) ? OutBits'(32768) : qx[k][OutBits-1:0];
        norm_d[k] = OutBits'(0) - qs[k];
      end else begin
        qs[k]     = (qx[k] > 33'd32767) ? OutBits'(32767) : qx[k][OutBits-1:0];
        norm_d[k] = qs[k];
      end
      if (fin.degen) begin
        norm_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= (OutBytes*8)'(norm_d);
      user_q <= fin.degen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

endmodule

`default_nettype wire

[bench/tfn_normal_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfn_normal_checker import tfn_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_ready_i,
  input  wire [InBytes*8-1:0]   in_data_i,
  input  wire                   out_valid_i,
  input  wire                   out_ready_i,
  input  wire [OutBytes*8-1:0]  out_data_i,
  input  wire                   out_degen_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
  } normal_t;

  normal_t normals_due[$];

  function automatic logic signed [25:0] coord(input logic [InBytes*8-1:0] d, input int idx);
    logic signed [CoordBits-1:0] c;
    begin
      c = d[idx*CoordBits +: CoordBits];
      return 26'(c);
    end
  endfunction

  function automatic logic [15:0] norm_comp(input logic [63:0] m, input logic neg,
                                            input logic [63:0] n);
    logic [63:0] q;
    begin
      q = ((m << FracBits) + (n >> 1)) / n;
      if (neg) begin
        if (q > 32768) q = 32768;
        return 16'(-q);
      end
      if (q > 32767) q = 32767;
      return q[15:0];
    end
  endfunction

  // Exact cross product, scale so the largest magnitude has bit length 30,
  // integer square root, then rounded division for each component.
  function automatic normal_t face_normal(input logic [InBytes*8-1:0] d);
    logic signed [25:0] e1[3];
    logic signed [25:0] e2[3];
    logic signed [67:0] c[3];
    logic [67:0] mag[3];
    logic [63:0] m[3];
    logic [63:0] sum;
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] bitv;
    int len;
    normal_t r;
    begin
      for (int i = 0; i < 3; i++) begin
        e1[i] = coord(d, 3 + i) - coord(d, i);
        e2[i] = coord(d, 6 + i) - coord(d, i);
      end
      c[0] = 68'(e1[1]) * 68'(e2[2]) - 68'(e1[2]) * 68'(e2[1]);
      c[1] = 68'(e1[2]) * 68'(e2[0]) - 68'(e1[0]) * 68'(e2[2]);
      c[2] = 68'(e1[0]) * 68'(e2[1]) - 68'(e1[1]) * 68'(e2[0]);
      len = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = c[i][67] ? -c[i] : c[i];
        for (int b = 0; b < 68; b++) if (mag[i][b] && b + 1 > len) len = b + 1;
      end
      r = '0;
      if (len == 0) begin
        r.degen = 1'b1;
        return r;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (len > 30) ? 64'(mag[i] >> (len - 30)) : 64'(mag[i] << (30 - len));
        sum += m[i] * m[i];
      end
      root = 0;
      rem = sum;
      bitv = 64'h1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      if (root == 0) root = 1;
      r.nx = norm_comp(m[0], c[0][67], root);
      r.ny = norm_comp(m[1], c[1][67], root);
      r.nz = norm_comp(m[2], c[2][67], root);
      return r;
    end
  endfunction

  always @(posedge clk_i) begin
    normal_t want;
    normal_t got;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        normals_due.insert(normals_due.size(), face_normal(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = {out_data_i[15:0], out_data_i[31:16], out_data_i[47:32], out_degen_i};
        if (normals_due.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = normals_due.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h degen=%b actual x=%h y=%h z=%h degen=%b",
                     $time, want.nx, want.ny, want.nz, want.degen,
                     got.nx, got.ny, got.nz, got.degen);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= normals_due.size();
    end
  end

endmodule

`default_nettype wire

[bench/tb_triangle_face_normal_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module tb_triangle_face_normal_unit;
  import tfn_pkg::*;

  localparam int WatchLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InBytes*8-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutBytes*8-1:0] m_axis_tdata;
  logic m_axis_tuser;
  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  triangle_face_normal_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  tfn_normal_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_i(m_axis_tdata),
    .out_degen_i(m_axis_tuser), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver stalls at the current rate, or fully during a hold-off.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: counts cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CoordBits-1:0] rand_coord(input int mode);
    case (mode)
      0: return CoordBits'($urandom);
      1: return CoordBits'($urandom_range(15)) - CoordBits'(8);
      2: return {1'b0, {(CoordBits-1){1'b1}}};
      default: return {1'b1, {(CoordBits-1){1'b0}}};
    endcase
  endfunction

  // Offers one triangle, idling beforehand at the sender's rate.
  task automatic send_triangle(input logic [InBytes*8-1:0] tri_data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= tri_data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(input int count);
    logic [InBytes*8-1:0] d;
    int style;
    for (int k = 0; k < count; k++) begin
      d = '0;
      style = $urandom_range(9);
      for (int i = 0; i < 9; i++) begin
        if (style < 6) d[i*CoordBits +: CoordBits] = rand_coord(0);
        else if (style < 8) d[i*CoordBits +: CoordBits] = rand_coord(1);
        else d[i*CoordBits +: CoordBits] = rand_coord($urandom_range(3));
      end
      // Now and then collapse a vertex by copying v1 into v2.
      if ($urandom_range(19) == 0) d[6*CoordBits +: 3*CoordBits] = d[3*CoordBits +: 3*CoordBits];
      send_triangle(d);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [InBytes*8-1:0] pack_tri(input int a[9]);
    logic [InBytes*8-1:0] d;
    begin
      d = '0;
      for (int i = 0; i < 9; i++) d[i*CoordBits +: CoordBits] = CoordBits'(a[i]);
      return d;
    end
  endfunction

  initial begin
    logic [CoordBits-1:0] mx;
    logic [CoordBits-1:0] mn;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    mx = {1'b0, {(CoordBits-1){1'b1}}};
    mn = {1'b1, {(CoordBits-1){1'b0}}};

    // Directed: axis-aligned faces, degenerate cases, full-range extremes.
    send_triangle(pack_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
    send_triangle(pack_tri('{0, 0, 0, 0, 1, 0, 1, 0, 0}));
    send_triangle(pack_tri('{0, 0, 0, 0, 0, 1, 1, 0, 0}));
    send_triangle(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_triangle(pack_tri('{5, 5, 5, 5, 5, 5, 9, 1, 3}));
    send_triangle(pack_tri('{0, 0, 0, 1, 2, 3, 2, 4, 6}));
    send_triangle(pack_tri('{1, 1, 1, 2, 3, 5, 7, 2, 4}));
    send_triangle({mx, mx, mx, mn, mx, mx, mx, mn, mx});
    send_triangle({mn, mn, mn, mx, mn, mn, mn, mx, mn});
    send_triangle({mn, mx, mn, mx, mn, mx, mn, mx, mx});
    send_triangle({mx, mn, mx, mn, mx, mn, mn, mn, mn});
    send_triangle({9{mx}});
    send_triangle({9{mn}});
    send_triangle({{3{24'hAAAAAA}}, {3{24'h555555}}, {3{24'h0F0F0F}}});
    send_triangle(pack_tri('{0, 0, 0, -1, -1, 0, 1, -1, 0}));
    drain;

    // No idling.
    send_random(100);
    drain;
    send_idle_pct = 80;
    send_random(80);
    drain;
    send_idle_pct = 0;
    recv_stall_pct = 80;
    send_random(80);
    drain;
    send_idle_pct = 7;
    recv_stall_pct = 7;
    send_random(120);

    // Long receiver hold-off while the sender keeps offering, filling the pipe.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(100);
    join
    drain;
    recv_stall_pct = 30;
    send_idle_pct = 30;
    send_random(40);
    drain;

    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
